>>> hw/rtl/qbs_pkg.sv
package qbs_pkg;

    // Field widths of the stream items
    localparam int CMD_W  = 1;
    localparam int WORD_W = 32;
    localparam int STAT_W = 2;

    typedef logic [CMD_W-1:0]  t_cmd;
    typedef logic [WORD_W-1:0] t_word;
    typedef logic [STAT_W-1:0] t_status;

    // Request kinds
    localparam t_cmd CMD_INSERT = 1'b0;
    localparam t_cmd CMD_REMOVE = 1'b1;

    // Result status codes
    localparam t_status STAT_OK    = 2'd0;
    localparam t_status STAT_EMPTY = 2'd1;
    localparam t_status STAT_FULL  = 2'd2;

endpackage

>>> hw/rtl/queue_of_bounded_stacks.sv
// Channel   Dir  Handshake             tdata               tuser
// s (req)   in   i_s_tvalid/o_s_tready data_in [31:0]      command [0]
// m (rsp)   out  o_m_tvalid/i_m_tready data_out [31:0]     status [1:0]
//
// One request is worked at a time; every request yields one response.
// An insert that opens the first stack and a remove with no stacks are answered
// straight from idle. Other inserts read the fill-count memory, then write back
// and answer. A pop reads the fill count, then the word memory, then answers;
// an emptied head stack is retired first and the next fill count read. A remove
// that retires the emptied sole stack answers empty after its fill-count read.
// Reset (synchronous, active low) clears the head slot, stack count and
// handshake state; memory contents are left as they are. A stalled response
// holds the request side off until it is taken.
module queue_of_bounded_stacks #(
    parameter int STACK_DEPTH = 8,
    parameter int MAX_STACKS  = 16,
    parameter int DATA_WIDTH  = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  qbs_pkg::t_word     i_s_tdata,   // [31:0] data_in
    input  qbs_pkg::t_cmd      i_s_tuser,   // [0] command
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output qbs_pkg::t_word     o_m_tdata,   // [31:0] data_out
    output qbs_pkg::t_status   o_m_tuser    // [1:0] status
);
    import qbs_pkg::*;

    localparam int SLOT_W = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
    localparam int CNT_W  = $clog2(MAX_STACKS + 1);
    localparam int SUM_W  = $clog2(2 * MAX_STACKS + 1);
    localparam int FILL_W = $clog2(STACK_DEPTH + 1);
    localparam int WORDS  = MAX_STACKS * STACK_DEPTH;
    localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int MEM_W  = (DATA_WIDTH < WORD_W) ? DATA_WIDTH : WORD_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_INS  = 2'd1;
    localparam logic [1:0] S_REM  = 2'd2;
    localparam logic [1:0] S_WORD = 2'd3;

    function automatic logic [ADDR_W-1:0] word_addr(input logic [SLOT_W-1:0] slot,
                                                   input logic [FILL_W-1:0] lvl);
        word_addr = ADDR_W'(slot) * ADDR_W'(STACK_DEPTH) + ADDR_W'(lvl);
    endfunction

    // Memories
    logic [MEM_W-1:0]  r_word_mem [WORDS];
    logic [FILL_W-1:0] r_fill_mem [MAX_STACKS];
    logic [MEM_W-1:0]  r_word_rdata;
    logic [FILL_W-1:0] r_fill_rdata;

    // Control and per-request registers
    logic [1:0]        r_state, n_state;
    logic [SLOT_W-1:0] r_head, n_head;
    logic [CNT_W-1:0]  r_inuse, n_inuse;
    logic              r_retired, n_retired;
    logic [SLOT_W-1:0] r_tail, n_tail;
    logic [SLOT_W-1:0] r_next, n_next;
    logic [MEM_W-1:0]  r_data, n_data;
    logic              r_ovalid, n_ovalid;
    t_word             r_odata, n_odata;
    t_status           r_ostat, n_ostat;

    // Memory port controls
    logic              w_word_we, w_word_re;
    logic [ADDR_W-1:0] w_word_waddr, w_word_raddr;
    logic [MEM_W-1:0]  w_word_wdata;
    logic              w_fill_we, w_fill_re;
    logic [SLOT_W-1:0] w_fill_waddr, w_fill_raddr;
    logic [FILL_W-1:0] w_fill_wdata;

    logic              w_accept;
    logic [SUM_W-1:0]  w_sum_next, w_sum_tail;
    logic [SLOT_W-1:0] w_next_slot, w_tail_slot, w_head_inc;
    logic [MEM_W-1:0]  w_in_word;

    assign o_s_tready = (r_state == S_IDLE) && (!r_ovalid || i_m_tready);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_in_word  = MEM_W'(i_s_tdata);

    // Ring slot arithmetic: sums stay below twice the slot count
    assign w_sum_next  = SUM_W'(r_head) + SUM_W'(r_inuse);
    assign w_sum_tail  = w_sum_next - SUM_W'(1);
    assign w_next_slot = (w_sum_next >= SUM_W'(MAX_STACKS))
                       ? SLOT_W'(w_sum_next - SUM_W'(MAX_STACKS)) : SLOT_W'(w_sum_next);
    assign w_tail_slot = (w_sum_tail >= SUM_W'(MAX_STACKS))
                       ? SLOT_W'(w_sum_tail - SUM_W'(MAX_STACKS)) : SLOT_W'(w_sum_tail);
    assign w_head_inc  = (r_head == SLOT_W'(MAX_STACKS - 1)) ? '0 : r_head + SLOT_W'(1);

    // Sequence one request through read, modify and write-back
    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_inuse      = r_inuse;
        n_retired    = r_retired;
        n_tail       = r_tail;
        n_next       = r_next;
        n_data       = r_data;
        n_ovalid     = r_ovalid && !i_m_tready;
        n_odata      = r_odata;
        n_ostat      = r_ostat;
        w_word_we    = 1'b0;
        w_word_waddr = '0;
        w_word_wdata = r_data;
        w_word_re    = 1'b0;
        w_word_raddr = '0;
        w_fill_we    = 1'b0;
        w_fill_waddr = '0;
        w_fill_wdata = '0;
        w_fill_re    = 1'b0;
        w_fill_raddr = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_data    = w_in_word;
                    n_tail    = w_tail_slot;
                    n_next    = w_next_slot;
                    n_retired = 1'b0;
                    if (i_s_tuser == CMD_INSERT) begin
                        if (r_inuse == '0) begin
                            // open the first stack right away
                            w_word_we    = 1'b1;
                            w_word_waddr = word_addr(w_next_slot, '0);
                            w_word_wdata = w_in_word;
                            w_fill_we    = 1'b1;
                            w_fill_waddr = w_next_slot;
                            w_fill_wdata = FILL_W'(1);
                            n_inuse      = r_inuse + CNT_W'(1);
                            n_ovalid     = 1'b1;
                            n_odata      = '0;
                            n_ostat      = STAT_OK;
                        end else begin
                            w_fill_re    = 1'b1;
                            w_fill_raddr = w_tail_slot;
                            n_state      = S_INS;
                        end
                    end else begin
                        if (r_inuse == '0) begin
                            n_ovalid = 1'b1;
                            n_odata  = '0;
                            n_ostat  = STAT_EMPTY;
                        end else begin
                            w_fill_re    = 1'b1;
                            w_fill_raddr = r_head;
                            n_state      = S_REM;
                        end
                    end
                end
            end
            S_INS: begin
                n_ovalid = 1'b1;
                n_odata  = '0;
                n_ostat  = STAT_OK;
                n_state  = S_IDLE;
                if (r_fill_rdata < FILL_W'(STACK_DEPTH)) begin
                    // push onto the tail stack
                    w_word_we    = 1'b1;
                    w_word_waddr = word_addr(r_tail, r_fill_rdata);
                    w_fill_we    = 1'b1;
                    w_fill_waddr = r_tail;
                    w_fill_wdata = r_fill_rdata + FILL_W'(1);
                end else if (r_inuse == CNT_W'(MAX_STACKS)) begin
                    // drop the word
                    n_ostat = STAT_FULL;
                end else begin
                    // open a new stack after the tail
                    w_word_we    = 1'b1;
                    w_word_waddr = word_addr(r_next, '0);
                    w_fill_we    = 1'b1;
                    w_fill_waddr = r_next;
                    w_fill_wdata = FILL_W'(1);
                    n_inuse      = r_inuse + CNT_W'(1);
                end
            end
            S_REM: begin
                if (r_fill_rdata != '0) begin
                    // pop the head stack
                    w_fill_we    = 1'b1;
                    w_fill_waddr = r_head;
                    w_fill_wdata = r_fill_rdata - FILL_W'(1);
                    w_word_re    = 1'b1;
                    w_word_raddr = word_addr(r_head, r_fill_rdata - FILL_W'(1));
                    n_state      = S_WORD;
                end else if (r_retired || r_inuse == CNT_W'(1)) begin
                    // nothing left to pop; retire the emptied head on first pass
                    if (!r_retired) begin
                        n_head  = w_head_inc;
                        n_inuse = r_inuse - CNT_W'(1);
                    end
                    n_ovalid = 1'b1;
                    n_odata  = '0;
                    n_ostat  = STAT_EMPTY;
                    n_state  = S_IDLE;
                end else begin
                    // retire the emptied head and look at the next stack
                    n_head       = w_head_inc;
                    n_inuse      = r_inuse - CNT_W'(1);
                    n_retired    = 1'b1;
                    w_fill_re    = 1'b1;
                    w_fill_raddr = w_head_inc;
                end
            end
            S_WORD: begin
                n_ovalid = 1'b1;
                n_odata  = t_word'(r_word_rdata);
                n_ostat  = STAT_OK;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Word store
    always_ff @(posedge i_clk) begin
        if (w_word_we) begin
            r_word_mem[w_word_waddr] <= w_word_wdata;
        end
        if (w_word_re) begin
            r_word_rdata <= r_word_mem[w_word_raddr];
        end
    end

    // Fill count store
    always_ff @(posedge i_clk) begin
        if (w_fill_we) begin
            r_fill_mem[w_fill_waddr] <= w_fill_wdata;
        end
        if (w_fill_re) begin
            r_fill_rdata <= r_fill_mem[w_fill_raddr];
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_inuse  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_inuse  <= n_inuse;
            r_ovalid <= n_ovalid;
        end
    end

    // Per-request payload
    always_ff @(posedge i_clk) begin
        r_retired <= n_retired;
        r_tail    <= n_tail;
        r_next    <= n_next;
        r_data    <= n_data;
        r_odata   <= n_odata;
        r_ostat   <= n_ostat;
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_ostat;

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;
    import qbs_pkg::*;

    localparam int STACK_DEPTH    = 8;
    localparam int MAX_STACKS     = 16;
    localparam int DATA_WIDTH     = 32;
    localparam int RANDOM_ITEMS   = 1800;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 12;

    // Receiver stall patterns
    typedef enum int {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_SPARSE,
        RDY_LONG_STALL
    } t_ready_mode;

    typedef struct packed {
        t_word   data;
        t_status status;
    } t_response;

    // Shadow copy of the stack ring; predicts one response per request
    class stack_queue_predictor #(int DEPTH = 8, int SLOTS = 16);
        t_word     word_store [SLOTS*DEPTH];
        int        stack_fill [SLOTS];
        int        head_slot;
        int        stacks_in_use;
        t_response expected_responses [$];
        int        mismatch_count;

        function new();
            head_slot      = 0;
            stacks_in_use  = 0;
            mismatch_count = 0;
            foreach (stack_fill[i]) stack_fill[i] = 0;
        endfunction

        function int pending();
            return expected_responses.size();
        endfunction

        task report_mismatch(input string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            mismatch_count++;
        endtask

        // Update the shadow state for one accepted request
        function void note_request(input t_cmd cmd, input t_word word);
            int        slot;
            bit        pushed;
            t_response rsp;
            rsp.data   = '0;
            rsp.status = STAT_OK;
            pushed     = 1'b0;
            if (cmd == CMD_INSERT) begin
                // push onto the tail stack while it has room
                if (stacks_in_use != 0) begin
                    slot = (head_slot + stacks_in_use - 1) % SLOTS;
                    if (stack_fill[slot] < DEPTH) begin
                        word_store[slot*DEPTH + stack_fill[slot]] = word;
                        stack_fill[slot]++;
                        pushed = 1'b1;
                    end
                end
                // otherwise open a new stack, or drop the word when the ring is full
                if (!pushed) begin
                    if (stacks_in_use >= SLOTS) begin
                        rsp.status = STAT_FULL;
                    end else begin
                        slot = (head_slot + stacks_in_use) % SLOTS;
                        word_store[slot*DEPTH] = word;
                        stack_fill[slot]       = 1;
                        stacks_in_use++;
                    end
                end
            end else begin
                if (stacks_in_use == 0) begin
                    rsp.status = STAT_EMPTY;
                end else begin
                    // retire an emptied head stack first
                    if (stack_fill[head_slot] == 0) begin
                        head_slot = (head_slot + 1) % SLOTS;
                        stacks_in_use--;
                        if (stacks_in_use == 0 || stack_fill[head_slot] == 0)
                            rsp.status = STAT_EMPTY;
                    end
                    if (rsp.status == STAT_OK) begin
                        stack_fill[head_slot]--;
                        rsp.data = word_store[head_slot*DEPTH + stack_fill[head_slot]];
                    end
                end
            end
            expected_responses.push_back(rsp);
        endfunction

        // Compare one accepted response with the oldest prediction
        task check_response(input t_word data, input t_status status);
            t_response rsp;
            if (expected_responses.size() == 0) begin
                report_mismatch($sformatf("unexpected response data %h status %0d",
                                          data, status));
            end else begin
                rsp = expected_responses.pop_front();
                if (data !== rsp.data)
                    report_mismatch($sformatf("data_out %h, predicted %h", data, rsp.data));
                if (status !== rsp.status)
                    report_mismatch($sformatf("status %0d, predicted %0d",
                                              status, rsp.status));
            end
        endtask
    endclass

    logic    i_clk      = 1'b0;
    logic    i_rst_n    = 1'b0;
    logic    i_s_tvalid = 1'b0;
    logic    o_s_tready;
    t_word   i_s_tdata  = '0;   // [31:0] data_in
    t_cmd    i_s_tuser  = CMD_INSERT;   // [0] command
    logic    o_m_tvalid;
    logic    i_m_tready = 1'b0;
    t_word   o_m_tdata;   // [31:0] data_out
    t_status o_m_tuser;   // [1:0] status

    stack_queue_predictor #(STACK_DEPTH, MAX_STACKS) sb;

    int          idle_cycles = 0;
    int          ready_hold  = 0;
    int          mode_left   = 0;
    t_ready_mode ready_mode  = RDY_ALWAYS;

    queue_of_bounded_stacks #(
        .STACK_DEPTH (STACK_DEPTH),
        .MAX_STACKS  (MAX_STACKS),
        .DATA_WIDTH  (DATA_WIDTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always #6 i_clk = ~i_clk;

    // Present one request and hold it until it is accepted
    task automatic send_request(input t_cmd cmd, input t_word word);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= word;
        i_s_tuser  <= cmd;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_request(cmd, word);
    endtask

    // Check responses, stall the response side, track idle cycles
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready)
                sb.check_response(o_m_tdata, o_m_tuser);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;

            // switch stall pattern now and then
            if (mode_left == 0) begin
                ready_mode = t_ready_mode'($urandom_range(0, 3));
                mode_left  = $urandom_range(20, 150);
            end else begin
                mode_left--;
            end
            case (ready_mode)
                RDY_ALWAYS: begin
                    i_m_tready <= 1'b1;
                end
                RDY_COIN: begin
                    i_m_tready <= 1'($urandom_range(0, 1));
                end
                RDY_SPARSE: begin
                    i_m_tready <= ($urandom_range(0, 3) == 0);
                end
                default: begin
                    if (ready_hold == 0) begin
                        ready_hold = $urandom_range(1, 24);
                        i_m_tready <= ~i_m_tready;
                    end else begin
                        ready_hold--;
                    end
                end
            endcase
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Stop a hung run
    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("queue_of_bounded_stacks regression: fail");
        $finish;
    end

    initial begin
        int    sent;
        int    phase_left;
        int    insert_pct;
        int    burst_left;
        int    gap;
        t_cmd  cmd;
        t_word word;

        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty remove, data extremes, emptied stacks, stack rollover
        send_request(CMD_REMOVE, 32'h1234_5678);
        send_request(CMD_INSERT, 32'hFFFF_FFFF);
        send_request(CMD_INSERT, 32'h0000_0000);
        send_request(CMD_REMOVE, 32'hFFFF_FFFF);
        send_request(CMD_REMOVE, 32'h0000_0000);
        send_request(CMD_REMOVE, 32'h0000_0000);
        send_request(CMD_INSERT, 32'hAAAA_AAAA);
        send_request(CMD_REMOVE, 32'h0000_0000);
        // push into the emptied sole stack, then fill it and open the next
        send_request(CMD_INSERT, 32'h5555_5555);
        for (int i = 1; i <= STACK_DEPTH; i++)
            send_request(CMD_INSERT, 32'h8000_0000 | i);
        for (int i = 0; i <= STACK_DEPTH; i++)
            send_request(CMD_REMOVE, 32'h0);

        // Random phases biased toward filling or draining the ring
        sent       = 0;
        phase_left = 0;
        insert_pct = 50;
        burst_left = $urandom_range(1, 30);
        while (sent < RANDOM_ITEMS) begin
            if (phase_left == 0) begin
                case ($urandom_range(0, 2))
                    0:       insert_pct = 90;
                    1:       insert_pct = 50;
                    default: insert_pct = 15;
                endcase
                phase_left = $urandom_range(30, 300);
            end
            phase_left--;
            cmd = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_REMOVE;
            case ($urandom_range(0, 9))
                0:       word = '0;
                1:       word = '1;
                default: word = $urandom;
            endcase
            send_request(cmd, word);
            sent++;

            // idle between bursts, sometimes not at all
            burst_left--;
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                if (gap > 0) begin
                    i_s_tvalid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                burst_left = $urandom_range(1, 30);
            end
        end
        i_s_tvalid <= 1'b0;

        // Drain outstanding responses
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.mismatch_count == 0)
            $display("queue_of_bounded_stacks regression: pass");
        else
            $display("queue_of_bounded_stacks regression: fail");
        $finish;
    end

endmodule
